// ===== rtl/core/motor_light_mark_stop_defines.svh =====
// Assertion macros shared by the motor mark-stop RTL.
`ifndef MOTOR_LIGHT_MARK_STOP_DEFINES_SVH
`define MOTOR_LIGHT_MARK_STOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MLMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MLMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mlms_pkg.sv =====
// Types and codes for the motor mark-stop controller.
package mlms_pkg;

  typedef enum logic [1:0] {
    OP_MOVE   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_TICK   = 2'd2,
    OP_CALIB  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_PREPARE = 4'b0010,
    PH_RUN     = 4'b0100,
    PH_CALIB   = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    CFG_DIRECTION = 2'd0,
    CFG_TIMEOUT   = 2'd1,
    CFG_CAL_COUNT = 2'd2
  } cfg_index_t;

  // Direction pin levels: bit 0 clockwise, bit 1 counter-clockwise.
  localparam logic [1:0] PIN_NONE = 2'b00;
  localparam logic [1:0] PIN_CW   = 2'b01;
  localparam logic [1:0] PIN_CCW  = 2'b10;

  localparam logic [15:0] TIMEOUT_RESET   = 16'd2000;
  localparam logic [15:0] CAL_COUNT_RESET = 16'd10000;

  // Threshold sits at low + 4/5 of the observed span.
  localparam int THR_NUM_SHIFT = 2;
  localparam int THR_DEN       = 5;

endpackage

// ===== rtl/core/motor_light_mark_stop.sv =====
// Motor mark-stop controller: averaging, dark/light detection, timeout, calibration.
// Path: out_tvalid rises once the input transaction has gone through the input register, then
//   one state-update pass into the result register.
// Throughput: 1 transaction per cycle, set by that single pass; out_tready low holds both registers.
// Reset: rst_n is synchronous, active low; phase goes idle, threshold to -1,
//   config registers to their defaults, both channels empty and in_tready low.
`include "motor_light_mark_stop_defines.svh"

module motor_light_mark_stop
  import mlms_pkg::*;
#(
  parameter int AVERAGE_COUNT = 10,
  parameter int SAMPLE_BITS   = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,

  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [15:0]             cfg_wdata,

  input  logic                    in_tvalid,
  output logic                    in_tready,
  // tdata, low bit up: sensor_sample, speed, zero fill
  input  logic [((SAMPLE_BITS+8+7)/8)*8-1:0] in_tdata,
  // tuser: operation
  input  logic [1:0]              in_tuser,

  output logic                    out_tvalid,
  input  logic                    out_tready,
  // tdata, low bit up: motor_speed, drive_cw, drive_ccw, moving, timed_out,
  // calibrating, light_threshold, averaged_reading, zero fill
  output logic [((2*SAMPLE_BITS+14+7)/8)*8-1:0] out_tdata
);

  localparam int SB       = SAMPLE_BITS;
  localparam int OUT_BITS = 2 * SB + 14;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // Sample accumulator and count widths.
  localparam int AVG_L   = $clog2(AVERAGE_COUNT);
  localparam int SUM_W   = SB + AVG_L;
  localparam int CNT_W   = $clog2(AVERAGE_COUNT + 1);

  // floor(sum / AVERAGE_COUNT) by a rounded-up reciprocal, exact for every sum.
  localparam int AVG_SHIFT = SUM_W + AVG_L;
  localparam int AVG_PW    = SUM_W + AVG_SHIFT + 1;
  localparam logic [AVG_SHIFT:0] AVG_RECIP = (AVG_SHIFT + 1)'(
    ((64'd1 << AVG_SHIFT) + AVERAGE_COUNT - 1) / AVERAGE_COUNT);

  // floor(span * 4 / 5) the same way.
  localparam int D_W       = SB + THR_NUM_SHIFT;
  localparam int THR_SHIFT = D_W + 3;
  localparam int THR_PW    = D_W + THR_SHIFT + 1;
  localparam logic [THR_SHIFT:0] THR_RECIP = (THR_SHIFT + 1)'(
    ((64'd1 << THR_SHIFT) + THR_DEN - 1) / THR_DEN);

  localparam logic [CNT_W-1:0] AVG_CNT = CNT_W'(AVERAGE_COUNT);

  // Configuration registers.
  logic        direction_ccw_r;
  logic [15:0] timeout_ms_r;
  logic [15:0] cal_samples_r;

  // Input register.
  logic          in_valid_r;
  op_t           in_op_r;
  logic [SB-1:0] in_sample_r;
  logic [7:0]    in_speed_r;

  // Controller state.
  phase_t              phase_r, phase_nxt;
  logic [SUM_W-1:0]    sample_sum_r, sample_sum_nxt;
  logic [CNT_W-1:0]    sample_count_r, sample_count_nxt;
  logic                seen_dark_r, seen_dark_nxt;
  logic [15:0]         elapsed_ms_r, elapsed_ms_nxt;
  logic signed [SB:0]  threshold_r, threshold_nxt;
  logic [SB-1:0]       low_seen_r, low_seen_nxt;
  logic [SB-1:0]       high_seen_r, high_seen_nxt;
  logic [15:0]         cal_count_r, cal_count_nxt;
  logic [7:0]          run_speed_r, run_speed_nxt;
  logic [1:0]          pin_r, pin_nxt;
  logic                timeout_flag_r, timeout_flag_nxt;
  logic [SB-1:0]       last_avg_r, last_avg_nxt;

  // Result register.
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  logic advance;

  // Datapath intermediates.
  logic [SUM_W-1:0]   sum_acc;
  logic [CNT_W-1:0]   cnt_acc;
  logic [AVG_PW-1:0]  avg_prod;
  logic [SB-1:0]      avg_val;
  logic signed [SB:0] avg_s;
  logic [SB-1:0]      hi_upd, lo_upd;
  logic [15:0]        cal_cnt_upd;
  logic [D_W-1:0]     span4;
  logic [THR_PW-1:0]  thr_prod;
  logic [SB-1:0]      thr_val;
  logic [15:0]        elapsed_upd;
  logic               run_nxt;
  logic               moving_nxt;
  logic               calib_nxt;

  // Move the held item on whenever the result slot is free or being emptied.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = rst_n && (!in_valid_r || advance);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Configuration writes; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_ccw_r <= 1'b0;
      timeout_ms_r    <= TIMEOUT_RESET;
      cal_samples_r   <= CAL_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIRECTION: direction_ccw_r <= cfg_wdata[0];
        CFG_TIMEOUT:   timeout_ms_r    <= cfg_wdata;
        CFG_CAL_COUNT: cal_samples_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register: capture on each accepted transaction, empty once it advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r     <= op_t'(in_tuser);
      in_sample_r <= in_tdata[SB-1:0];
      in_speed_r  <= in_tdata[SB +: 8];
    end
  end

  // One state-update pass per item.
  always_comb begin
    phase_nxt        = phase_r;
    sample_sum_nxt   = sample_sum_r;
    sample_count_nxt = sample_count_r;
    seen_dark_nxt    = seen_dark_r;
    elapsed_ms_nxt   = elapsed_ms_r;
    threshold_nxt    = threshold_r;
    low_seen_nxt     = low_seen_r;
    high_seen_nxt    = high_seen_r;
    cal_count_nxt    = cal_count_r;
    run_speed_nxt    = run_speed_r;
    pin_nxt          = pin_r;
    timeout_flag_nxt = timeout_flag_r;
    last_avg_nxt     = last_avg_r;

    // Averaging path.
    sum_acc  = sample_sum_r + SUM_W'(in_sample_r);
    cnt_acc  = sample_count_r + CNT_W'(1);
    avg_prod = AVG_PW'(sum_acc) * AVG_PW'(AVG_RECIP);
    avg_val  = avg_prod[AVG_SHIFT +: SB];
    avg_s    = $signed({1'b0, avg_val});

    // Calibration path: running extremes and the new threshold.
    hi_upd      = (in_sample_r > high_seen_r) ? in_sample_r : high_seen_r;
    lo_upd      = (in_sample_r < low_seen_r) ? in_sample_r : low_seen_r;
    cal_cnt_upd = (cal_count_r != 16'hFFFF) ? cal_count_r + 16'd1 : cal_count_r;
    span4       = {hi_upd - lo_upd, {THR_NUM_SHIFT{1'b0}}};
    thr_prod    = THR_PW'(span4) * THR_PW'(THR_RECIP);
    thr_val     = lo_upd + thr_prod[THR_SHIFT +: SB];

    // Saturating millisecond count.
    elapsed_upd = (elapsed_ms_r != 16'hFFFF) ? elapsed_ms_r + 16'd1 : elapsed_ms_r;

    unique case (in_op_r)
      OP_MOVE: begin
        // Restart: average with the motor off first.
        phase_nxt        = PH_PREPARE;
        sample_sum_nxt   = '0;
        sample_count_nxt = '0;
        seen_dark_nxt    = 1'b0;
        elapsed_ms_nxt   = '0;
        timeout_flag_nxt = 1'b0;
        run_speed_nxt    = in_speed_r;
      end
      OP_SAMPLE: begin
        if (phase_r == PH_CALIB) begin
          high_seen_nxt = hi_upd;
          low_seen_nxt  = lo_upd;
          cal_count_nxt = cal_cnt_upd;
          if (cal_cnt_upd >= cal_samples_r) begin
            threshold_nxt = $signed({1'b0, thr_val});
            phase_nxt     = PH_IDLE;
          end
        end else if (phase_r == PH_PREPARE || phase_r == PH_RUN) begin
          sample_sum_nxt   = sum_acc;
          sample_count_nxt = cnt_acc;
          if (cnt_acc == AVG_CNT) begin
            sample_sum_nxt   = '0;
            sample_count_nxt = '0;
            last_avg_nxt     = avg_val;
            if (phase_r == PH_PREPARE) begin
              // Starting on dark counts as dark already seen.
              seen_dark_nxt = (avg_s <= threshold_r);
              phase_nxt     = PH_RUN;
              if (run_speed_r != 8'd0) begin
                pin_nxt = direction_ccw_r ? PIN_CCW : PIN_CW;
              end
            end else if (!seen_dark_r) begin
              if (avg_s < threshold_r) begin
                seen_dark_nxt = 1'b1;
              end
            end else if (avg_s > threshold_r) begin
              // Light again after the mark: stop.
              phase_nxt = PH_IDLE;
            end
          end
        end
      end
      OP_TICK: begin
        if (phase_r == PH_PREPARE || phase_r == PH_RUN) begin
          elapsed_ms_nxt = elapsed_upd;
          if (elapsed_upd > timeout_ms_r) begin
            phase_nxt        = PH_IDLE;
            timeout_flag_nxt = 1'b1;
          end
        end
      end
      OP_CALIB: begin
        // Restart calibration; the timeout flag is kept.
        phase_nxt     = PH_CALIB;
        low_seen_nxt  = '1;
        high_seen_nxt = '0;
        cal_count_nxt = '0;
        run_speed_nxt = in_speed_r;
        if (in_speed_r != 8'd0) begin
          pin_nxt = direction_ccw_r ? PIN_CCW : PIN_CW;
        end
      end
      default: ;
    endcase

    // Result shows the state after this item.
    run_nxt    = (phase_nxt == PH_RUN) || (phase_nxt == PH_CALIB);
    moving_nxt = (phase_nxt == PH_PREPARE) || (phase_nxt == PH_RUN);
    calib_nxt  = (phase_nxt == PH_CALIB);

    out_data_nxt = OUT_W'({
      last_avg_nxt,
      threshold_nxt,
      calib_nxt,
      timeout_flag_nxt,
      moving_nxt,
      pin_nxt[1],
      pin_nxt[0],
      (run_nxt ? run_speed_nxt : 8'd0)
    });
  end

  // Commit state when the item advances.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      sample_sum_r   <= '0;
      sample_count_r <= '0;
      seen_dark_r    <= 1'b0;
      elapsed_ms_r   <= '0;
      threshold_r    <= '1;
      low_seen_r     <= '1;
      high_seen_r    <= '0;
      cal_count_r    <= '0;
      run_speed_r    <= '0;
      pin_r          <= PIN_NONE;
      timeout_flag_r <= 1'b0;
      last_avg_r     <= '0;
    end else if (advance) begin
      phase_r        <= phase_nxt;
      sample_sum_r   <= sample_sum_nxt;
      sample_count_r <= sample_count_nxt;
      seen_dark_r    <= seen_dark_nxt;
      elapsed_ms_r   <= elapsed_ms_nxt;
      threshold_r    <= threshold_nxt;
      low_seen_r     <= low_seen_nxt;
      high_seen_r    <= high_seen_nxt;
      cal_count_r    <= cal_count_nxt;
      run_speed_r    <= run_speed_nxt;
      pin_r          <= pin_nxt;
      timeout_flag_r <= timeout_flag_nxt;
      last_avg_r     <= last_avg_nxt;
    end
  end

  // Result register: load on advance, hold until the transaction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  `MLMS_ASSERT_NEXT(a_held_item_kept, in_valid_r && !advance, in_valid_r, "held item lost")
  `MLMS_ASSERT_NEXT(a_result_made, advance, out_valid_r, "advanced item left no result")
  `MLMS_ASSERT_NOW(a_pins_exclusive, 1'b1, pin_r != 2'b11, "both direction pins driven")
  `MLMS_ASSERT_NOW(a_count_bound, 1'b1, sample_count_r < AVG_CNT, "sample count overran")
  `MLMS_ASSERT_NOW(a_timeout_stops, $rose(timeout_flag_r), phase_r == PH_IDLE,
                   "timeout without stop")

endmodule

// ===== verif/motor_light_mark_stop_test.sv =====
// Self-checking stream testbench for the motor mark-stop controller.
module motor_light_mark_stop_test;
  import mlms_pkg::*;

  localparam int SAMPLE_W     = 10;
  localparam int IN_W         = ((SAMPLE_W + 8 + 7) / 8) * 8;
  localparam int OUT_W        = ((2 * SAMPLE_W + 14 + 7) / 8) * 8;
  localparam int AVG_N        = 10;
  localparam int GAP_MAX      = 17;
  localparam int ITEM_TARGET  = 1950;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DIR_ROWS     = 21;

  // One result as seen on out_tdata; members run from the top bit down.
  typedef struct packed {
    logic [7:0]  motor_speed;
    logic        drive_cw;
    logic        drive_ccw;
    logic        moving;
    logic        timed_out;
    logic        calibrating;
    logic [10:0] threshold;
    logic [9:0]  average;
  } mark_result_t;

  // One directed stimulus row; want is only meaningful when typed is set.
  typedef struct packed {
    op_t          op;
    logic [9:0]   smp;
    logic [7:0]   spd;
    logic         typed;
    mark_result_t want;
  } dir_row_t;

  // Hand-written expectations:      speed  cw ccw mov tmo cal  threshold  average
  localparam mark_result_t AT_REST   = {8'd0,   5'b00000, 11'h7FF, 10'd0};
  localparam mark_result_t PREP_OFF  = {8'd0,   5'b00100, 11'h7FF, 10'd0};
  localparam mark_result_t RUN_FULL  = {8'd255, 5'b10100, 11'h7FF, 10'd0};
  localparam mark_result_t CAL_ZERO  = {8'd0,   5'b10001, 11'h7FF, 10'd0};
  localparam mark_result_t PREP_CW   = {8'd0,   5'b10100, 11'h7FF, 10'd0};

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [15:0]      cfg_wdata = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;   // low bit up: sensor_sample, speed, zero fill
  logic [1:0]       in_tuser = '0;   // operation
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  // low bit up: motor_speed, drive_cw, drive_ccw, moving, timed_out, calibrating,
  // light_threshold, averaged_reading, zero fill
  logic [OUT_W-1:0] out_tdata;

  motor_light_mark_stop u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Predicted controller state and register copies.
  phase_t      ph;
  int          acc_sum;
  int          acc_n;
  bit          dark_seen;
  logic [15:0] ms_count;
  logic signed [10:0] thr_level;
  logic [9:0]  cal_low;
  logic [9:0]  cal_high;
  logic [15:0] cal_seen;
  logic [7:0]  duty;
  logic [1:0]  pins;
  bit          tmo_hit;
  logic [9:0]  avg_last;
  bit          ccw_sel;
  logic [15:0] tmo_limit;
  logic [15:0] cal_target;

  mark_result_t mark_expect_q[$];
  dir_row_t     dir_tab [DIR_ROWS];
  int           mark_errors = 0;
  int           items_sent = 0;
  int           cycles = 0;
  bit           in_idle = 1'b1;
  bit           out_idle = 1'b1;

  // Advance the predicted controller by one transaction and return its view.
  function automatic mark_result_t mark_step(op_t op, logic [9:0] smp, logic [7:0] spd);
    int avg;
    int t;
    int lo;
    int hi;
    mark_result_t r;
    case (op)
      OP_MOVE: begin
        ph        = PH_PREPARE;
        acc_sum   = 0;
        acc_n     = 0;
        dark_seen = 1'b0;
        ms_count  = '0;
        tmo_hit   = 1'b0;
        duty      = spd;
      end
      OP_SAMPLE: begin
        if (ph == PH_CALIB) begin
          if (smp > cal_high) cal_high = smp;
          if (smp < cal_low) cal_low = smp;
          if (cal_seen != 16'hFFFF) cal_seen++;
          // a zero target behaves as one: the first sample closes calibration
          if (cal_seen >= cal_target) begin
            lo = cal_low;
            hi = cal_high;
            thr_level = 11'(lo + ((hi - lo) * 4) / 5);
            ph = PH_IDLE;
          end
        end else if (ph == PH_PREPARE || ph == PH_RUN) begin
          acc_sum += smp;
          acc_n++;
          if (acc_n == AVG_N) begin
            avg      = acc_sum / AVG_N;
            t        = thr_level;
            acc_sum  = 0;
            acc_n    = 0;
            avg_last = 10'(avg);
            if (ph == PH_PREPARE) begin
              // at-or-below on the first average, strictly below afterwards
              dark_seen = (avg <= t);
              ph = PH_RUN;
              if (duty != 0) pins = ccw_sel ? PIN_CCW : PIN_CW;
            end else if (!dark_seen) begin
              if (avg < t) dark_seen = 1'b1;
            end else if (avg > t) begin
              ph = PH_IDLE;
            end
          end
        end
      end
      OP_TICK: begin
        if (ph == PH_PREPARE || ph == PH_RUN) begin
          if (ms_count != 16'hFFFF) ms_count++;
          if (ms_count > tmo_limit) begin
            ph      = PH_IDLE;
            tmo_hit = 1'b1;
          end
        end
      end
      default: begin
        ph       = PH_CALIB;
        cal_low  = '1;
        cal_high = '0;
        cal_seen = '0;
        duty     = spd;
        if (duty != 0) pins = ccw_sel ? PIN_CCW : PIN_CW;
      end
    endcase
    r.motor_speed = (ph == PH_RUN || ph == PH_CALIB) ? duty : 8'd0;
    r.drive_cw    = pins[0];
    r.drive_ccw   = pins[1];
    r.moving      = (ph == PH_PREPARE || ph == PH_RUN);
    r.timed_out   = tmo_hit;
    r.calibrating = (ph == PH_CALIB);
    r.threshold   = thr_level;
    r.average     = avg_last;
    return r;
  endfunction

  function automatic string show(mark_result_t r);
    return $sformatf("speed=%0d cw=%0b ccw=%0b moving=%0b tmo=%0b cal=%0b thr=%0d avg=%0d",
                     r.motor_speed, r.drive_cw, r.drive_ccw, r.moving, r.timed_out,
                     r.calibrating, $signed(r.threshold), r.average);
  endfunction

  // Write one register; the pipeline is empty, so the copy is updated right away.
  task automatic cfg_write(cfg_index_t idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DIRECTION: ccw_sel    = val[0];
      CFG_TIMEOUT:   tmo_limit  = val;
      default:       cal_target = val;
    endcase
    @(posedge clk);
  endtask

  // Offer one transaction (after a random gap if in_idle is set), hold it until taken, then queue
  // the prediction (or the hand-written value for typed directed rows).
  task automatic push_checked(op_t op, logic [9:0] smp, logic [7:0] spd, bit typed,
                              mark_result_t want);
    int gap;
    mark_result_t pred;
    gap = in_idle ? $urandom_range(0, GAP_MAX) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W - 18){1'b0}}, spd, smp};
    in_tuser  <= op;
    do @(posedge clk); while (in_tready !== 1'b1);
    items_sent++;
    pred = mark_step(op, smp, spd);
    mark_expect_q.push_back(typed ? want : pred);
  endtask

  task automatic push_item(op_t op, int smp, int spd);
    push_checked(op, 10'(smp), 8'(spd), 1'b0, '0);
  endtask

  // Drop valid, wait out every pending result, then the pipeline depth.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (mark_expect_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Calibration over a random sample band, edges of the band hit often.
  task automatic run_calibration();
    int lo;
    int hi;
    int n;
    case ($urandom_range(0, 7))
      0: begin lo = 1023; hi = 1023; end
      1: begin lo = 0; hi = 0; end
      2: begin lo = 0; hi = 1023; end
      default: begin
        lo = $urandom_range(0, 1023);
        hi = $urandom_range(lo, 1023);
      end
    endcase
    push_item(OP_CALIB, $urandom_range(0, 1023), $urandom_range(0, 255));
    n = 0;
    while (ph == PH_CALIB && n < 80) begin
      if ($urandom_range(0, 9) == 0)
        push_item(OP_TICK, $urandom_range(0, 1023), $urandom_range(0, 255));
      else if ($urandom_range(0, 3) == 0)
        push_item(OP_SAMPLE, $urandom_range(0, 1) ? lo : hi, $urandom_range(0, 255));
      else
        push_item(OP_SAMPLE, $urandom_range(lo, hi), $urandom_range(0, 255));
      n++;
    end
  endtask

  // A move: blocks of ten samples steered dark, light or onto the threshold,
  // with ticks mixed in and the odd restart.
  task automatic run_move();
    int avgs;
    int k;
    int t;
    int target;
    int lvl;
    int j;
    int tick_odds;
    tick_odds = ($urandom_range(0, 9) < 3) ? 2 : 8;
    push_item(OP_MOVE, $urandom_range(0, 1023), $urandom_range(0, 255));
    avgs = 0;
    while ((ph == PH_PREPARE || ph == PH_RUN) && avgs < 10) begin
      t   = thr_level;
      lvl = $urandom_range(0, 4);
      if (t < 0)
        target = $urandom_range(0, 1023);
      else if (lvl < 2)
        target = (t == 0) ? 0 : $urandom_range((t > 80) ? t - 80 : 0, t - 1);
      else if (lvl < 4)
        target = (t == 1023) ? 1023 : $urandom_range(t + 1, (t < 943) ? t + 80 : 1023);
      else
        target = t;
      for (k = 0; k < AVG_N; k++) begin
        if ($urandom_range(1, tick_odds) == 1)
          push_item(OP_TICK, $urandom_range(0, 1023), $urandom_range(0, 255));
        j = target;
        if ($urandom_range(0, 1)) j = target + $urandom_range(0, 4) - 2;
        if (j < 0) j = 0;
        if (j > 1023) j = 1023;
        push_item(OP_SAMPLE, j, $urandom_range(0, 255));
      end
      if ($urandom_range(0, 39) == 0)
        push_item($urandom_range(0, 1) ? OP_MOVE : OP_CALIB, $urandom_range(0, 1023),
                  $urandom_range(0, 255));
      avgs++;
    end
  endtask

  // Check each accepted result against the oldest expectation.
  initial begin
    mark_result_t got;
    mark_result_t want;
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = out_idle ? $urandom_range(0, GAP_MAX) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      got.motor_speed = out_tdata[7:0];
      got.drive_cw    = out_tdata[8];
      got.drive_ccw   = out_tdata[9];
      got.moving      = out_tdata[10];
      got.timed_out   = out_tdata[11];
      got.calibrating = out_tdata[12];
      got.threshold   = out_tdata[23:13];
      got.average     = out_tdata[33:24];
      if (mark_expect_q.size() == 0) begin
        if (mark_errors < 10) $display("unexpected result: %s", show(got));
        mark_errors++;
      end else begin
        want = mark_expect_q.pop_front();
        if (got.motor_speed !== want.motor_speed || got.drive_cw !== want.drive_cw ||
            got.drive_ccw !== want.drive_ccw || got.moving !== want.moving ||
            got.timed_out !== want.timed_out || got.calibrating !== want.calibrating ||
            got.threshold !== want.threshold || got.average !== want.average) begin
          if (mark_errors < 10) begin
            $display("mismatch expected: %s", show(want));
            $display("         actual:   %s", show(got));
          end
          mark_errors++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int i;
    int pick;
    int tsel;

    // Reset values of the predicted state and register copies.
    ph = PH_IDLE; acc_sum = 0; acc_n = 0; dark_seen = 1'b0; ms_count = '0;
    thr_level = -11'sd1; cal_low = '1; cal_high = '0; cal_seen = '0; duty = '0;
    pins = PIN_NONE; tmo_hit = 1'b0; avg_last = '0;
    ccw_sel = 1'b0; tmo_limit = TIMEOUT_RESET; cal_target = CAL_COUNT_RESET;

    // Directed rows: idle inputs, an uncalibrated move at full speed, a zero
    // speed calibration that keeps the pins, and restarts mid-flight.
    dir_tab[0]  = {OP_TICK,   10'd0,    8'd0,   1'b1, AT_REST};
    dir_tab[1]  = {OP_SAMPLE, 10'd1023, 8'd0,   1'b1, AT_REST};
    dir_tab[2]  = {OP_MOVE,   10'd1023, 8'd255, 1'b1, PREP_OFF};
    for (i = 3; i < 12; i++)
      dir_tab[i] = {OP_SAMPLE, 10'd0, 8'd0, 1'b0, AT_REST};
    dir_tab[12] = {OP_SAMPLE, 10'd0,    8'd0,   1'b1, RUN_FULL};
    dir_tab[13] = {OP_TICK,   10'd0,    8'd0,   1'b0, AT_REST};
    dir_tab[14] = {OP_CALIB,  10'd0,    8'd0,   1'b1, CAL_ZERO};
    dir_tab[15] = {OP_SAMPLE, 10'd1023, 8'd0,   1'b0, AT_REST};
    dir_tab[16] = {OP_SAMPLE, 10'd0,    8'd0,   1'b0, AT_REST};
    dir_tab[17] = {OP_TICK,   10'd0,    8'd0,   1'b0, AT_REST};
    dir_tab[18] = {OP_MOVE,   10'd0,    8'd1,   1'b1, PREP_CW};
    dir_tab[19] = {OP_SAMPLE, 10'd512,  8'd255, 1'b0, AT_REST};
    dir_tab[20] = {OP_MOVE,   10'd0,    8'd128, 1'b0, AT_REST};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_ROWS; i++)
      push_checked(dir_tab[i].op, dir_tab[i].smp, dir_tab[i].spd, dir_tab[i].typed,
                   dir_tab[i].want);

    // Zero calibration count acts as one: a single sample sets the threshold.
    settle();
    cfg_write(CFG_DIRECTION, 16'd1);
    cfg_write(CFG_CAL_COUNT, 16'd0);
    push_item(OP_CALIB, 0, 200);
    push_item(OP_SAMPLE, 700, 0);
    run_move();

    // Longest calibration, cut short by lowering the count below what has run.
    settle();
    cfg_write(CFG_CAL_COUNT, 16'hFFFF);
    push_item(OP_CALIB, 0, 7);
    repeat (20) push_item(OP_SAMPLE, $urandom_range(0, 1023), $urandom_range(0, 255));
    settle();
    cfg_write(CFG_CAL_COUNT, 16'd5);
    push_item(OP_SAMPLE, $urandom_range(0, 1023), 0);
    run_move();

    // Zero timeout: the first tick of a move times it out.
    settle();
    cfg_write(CFG_TIMEOUT, 16'd0);
    push_item(OP_MOVE, 0, 50);
    push_item(OP_TICK, 0, 0);
    run_move();

    // Largest timeout: run ticks back to back without tripping it, then drop
    // the limit so the next tick trips it.
    settle();
    in_idle  = 1'b0;
    out_idle = 1'b0;
    cfg_write(CFG_TIMEOUT, 16'hFFFF);
    push_item(OP_MOVE, 0, 3);
    repeat (200) push_item(OP_TICK, 0, 0);
    settle();
    cfg_write(CFG_TIMEOUT, 16'd100);
    push_item(OP_TICK, 0, 0);

    // Random phases until the run reaches its item count: new registers and
    // idling each time, then a scenario.
    while (items_sent < ITEM_TARGET) begin
      settle();
      in_idle  = ($urandom_range(0, 9) < 7);
      out_idle = ($urandom_range(0, 9) < 7);
      if ($urandom_range(0, 1)) cfg_write(CFG_DIRECTION, 16'($urandom_range(0, 1)));
      if ($urandom_range(0, 1)) begin
        tsel = $urandom_range(0, 9);
        if (tsel == 0)
          cfg_write(CFG_TIMEOUT, 16'd0);
        else if (tsel == 1)
          cfg_write(CFG_TIMEOUT, 16'hFFFF);
        else if (tsel < 7)
          cfg_write(CFG_TIMEOUT, 16'($urandom_range(1, 40)));
        else
          cfg_write(CFG_TIMEOUT, 16'($urandom_range(41, 400)));
      end
      if ($urandom_range(0, 1)) cfg_write(CFG_CAL_COUNT, 16'($urandom_range(0, 40)));
      pick = $urandom_range(0, 19);
      if (pick < 5) begin
        run_calibration();
      end else if (pick < 17) begin
        run_move();
      end else begin
        // noise: any operation, any field value
        repeat (20)
          push_item(op_t'($urandom_range(0, 3)), $urandom_range(0, 1023),
                    $urandom_range(0, 255));
      end
    end

    settle();
    if (mark_errors == 0 && mark_expect_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
